// ----- src/dsm3_pkg.sv -----
`timescale 1ns / 1ps
package dsm3_pkg;

  localparam int POS_W   = 17;
  localparam int DIGIT_W = 4;
  localparam int COUNT_W = 32;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DOWN,
    ST_SIB_RD,
    ST_MERGE,
    ST_VISIT,
    ST_ACC,
    ST_PAIR,
    ST_OUT
  } state_t;

  // residue of one 4-bit digit
  function automatic logic [1:0] digit_mod3(input logic [DIGIT_W-1:0] d);
    logic [1:0] r;
    case (d)
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: r = 2'd0;
      4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       r = 2'd1;
      default:                              r = 2'd2;
    endcase
    return r;
  endfunction

endpackage

// ----- src/dsm3_ram.sv -----
`timescale 1ns / 1ps
module dsm3_ram #(
  parameter int WIDTH = 53,
  parameter int DEPTH = 131072
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/digit_sum_mod3_substring_counter.sv -----
`timescale 1ns / 1ps
// Segment tree over a digit string (positions 1..string_length) that counts
// substrings of a range whose digit sum is divisible by three. Each tree node
// in one node RAM holds its span's residue and three prefix counts. After
// reset the block sweeps the whole RAM to zero, one node a cycle (all
// 2*TREE_SPAN nodes, 131072 at the default MAX_LENGTH), and takes no word
// meanwhile. A write walks down one level a cycle and then re-merges up with
// one sibling read and then one merge and write per level. A query walks the
// tree depth first with a small stack, one node visit a cycle plus an
// accumulate step per covering node read, at most about 4 visits a level,
// then forms the pair counts in one shared multiplier. One word is in work
// at a time.
module digit_sum_mod3_substring_counter #(
  parameter int MAX_LENGTH = 65536
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [dsm3_pkg::POS_W-1:0]  cfg_data,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic                        opcode,
  input  logic [dsm3_pkg::POS_W-1:0]  update_position,
  input  logic [dsm3_pkg::DIGIT_W-1:0] new_digit,
  input  logic [dsm3_pkg::POS_W-1:0]  query_first,
  input  logic [dsm3_pkg::POS_W-1:0]  query_last,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [dsm3_pkg::COUNT_W-1:0] substring_count
);

  localparam int TREE_SPAN = 2 ** $clog2(MAX_LENGTH);
  localparam int NODE_COUNT = 2 * TREE_SPAN;
  localparam int IDXW = $clog2(NODE_COUNT);
  localparam int CW = $clog2(MAX_LENGTH + 1);
  localparam int NW = 3 * CW + 2;
  localparam int LW = (CW > dsm3_pkg::POS_W) ? CW : dsm3_pkg::POS_W;
  localparam int STK_DEPTH = $clog2(TREE_SPAN) + 1;
  localparam int SIW = $clog2(STK_DEPTH);
  localparam int SPW = $clog2(STK_DEPTH + 1);
  localparam int PW = 2 * (CW + 1);
  localparam int SW = PW + 1;

  function automatic logic [NW-1:0] join_nodes(input logic [NW-1:0] a,
                                               input logic [NW-1:0] b);
    logic [1:0]    sa;
    logic [1:0]    sb;
    logic [2:0]    s;
    logic [CW-1:0] a0, a1, a2, b0, b1, b2, m0, m1, m2;
    sa = a[NW-1 -: 2];
    sb = b[NW-1 -: 2];
    a0 = a[0 +: CW];
    a1 = a[CW +: CW];
    a2 = a[2*CW +: CW];
    b0 = b[0 +: CW];
    b1 = b[CW +: CW];
    b2 = b[2*CW +: CW];
    case (sa)
      2'd1: begin
        m0 = a0 + b2;
        m1 = a1 + b0;
        m2 = a2 + b1;
      end
      2'd2: begin
        m0 = a0 + b1;
        m1 = a1 + b2;
        m2 = a2 + b0;
      end
      default: begin
        m0 = a0 + b0;
        m1 = a1 + b1;
        m2 = a2 + b2;
      end
    endcase
    s = {1'b0, sa} + {1'b0, sb};
    if (s >= 3'd3) begin
      s = s - 3'd3;
    end
    return {s[1:0], m2, m1, m0};
  endfunction

  dsm3_pkg::state_t state, state_next;

  logic [IDXW-1:0] clr_addr;
  logic [LW-1:0]   string_length;
  logic [IDXW-1:0] idx;
  logic [LW-1:0]   lo, hi, pos, first, last;
  logic [1:0]      digit_res;
  logic [NW-1:0]   cur;
  logic [NW-1:0]   acc;
  logic [IDXW-1:0] stk_idx [STK_DEPTH];
  logic [LW-1:0]   stk_lo [STK_DEPTH];
  logic [LW-1:0]   stk_hi [STK_DEPTH];
  logic [SPW-1:0]  sp;
  logic [1:0]      kc;
  logic [PW-1:0]   prod;
  logic [SW-1:0]   sum;

  logic            ram_we;
  logic [IDXW-1:0] ram_waddr, ram_raddr;
  logic [NW-1:0]   ram_wdata, ram_rdata;

  logic [LW-1:0]   mid;
  logic            is_leaf, disjoint, covered, stk_empty, accept;
  logic [NW-1:0]   leaf_node, merged, acc_joined;
  logic [IDXW-1:0] parent;
  logic [CW:0]     c_sel;
  logic [SW-1:0]   total;
  logic [LW-1:0]   cfg_len;

  dsm3_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_nodes (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign item_stall   = (state != dsm3_pkg::ST_IDLE);
  assign result_valid = (state == dsm3_pkg::ST_OUT);
  assign accept       = item_valid && !item_stall;

  assign mid       = LW'(({1'b0, lo} + {1'b0, hi}) >> 1);
  assign is_leaf   = (lo >= hi);
  assign disjoint  = (first > hi) || (last < lo);
  assign covered   = (first <= lo) && (last >= hi);
  assign stk_empty = (sp == '0);
  assign parent    = idx >> 1;

  always_comb begin
    leaf_node = '0;
    leaf_node[NW-1 -: 2] = digit_res;
    leaf_node[32'(digit_res) * CW +: CW] = CW'(1);
  end

  assign merged     = idx[0] ? join_nodes(ram_rdata, cur) : join_nodes(cur, ram_rdata);
  assign acc_joined = join_nodes(acc, ram_rdata);

  always_comb begin
    case (kc)
      2'd0:    c_sel = {1'b0, acc[0 +: CW]} + (CW+1)'(1);
      2'd1:    c_sel = {1'b0, acc[CW +: CW]};
      default: c_sel = {1'b0, acc[2*CW +: CW]};
    endcase
  end

  assign total = sum + SW'(prod >> 1);

  always_comb begin
    cfg_len = LW'(cfg_data);
    if (cfg_len == '0) begin
      cfg_len = LW'(1);
    end
    if (cfg_len > LW'(MAX_LENGTH)) begin
      cfg_len = LW'(MAX_LENGTH);
    end
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = idx;
    ram_wdata  = leaf_node;
    ram_raddr  = idx;
    unique case (state)
      dsm3_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
        if (clr_addr == IDXW'(NODE_COUNT - 1)) begin
          state_next = dsm3_pkg::ST_IDLE;
        end
      end
      dsm3_pkg::ST_IDLE: begin
        if (accept) begin
          if (opcode == dsm3_pkg::OP_WRITE) begin
            if (update_position != '0 && LW'(update_position) <= string_length) begin
              state_next = dsm3_pkg::ST_DOWN;
            end
          end else if (query_first > query_last) begin
            state_next = dsm3_pkg::ST_PAIR;
          end else begin
            state_next = dsm3_pkg::ST_VISIT;
          end
        end
      end
      dsm3_pkg::ST_DOWN: begin
        if (is_leaf) begin
          ram_we = 1'b1;
          state_next = (idx == IDXW'(1)) ? dsm3_pkg::ST_IDLE : dsm3_pkg::ST_SIB_RD;
        end
      end
      dsm3_pkg::ST_SIB_RD: begin
        ram_raddr  = idx ^ IDXW'(1);
        state_next = dsm3_pkg::ST_MERGE;
      end
      dsm3_pkg::ST_MERGE: begin
        ram_we     = 1'b1;
        ram_waddr  = parent;
        ram_wdata  = merged;
        state_next = (parent == IDXW'(1)) ? dsm3_pkg::ST_IDLE : dsm3_pkg::ST_SIB_RD;
      end
      dsm3_pkg::ST_VISIT: begin
        if (disjoint) begin
          if (stk_empty) begin
            state_next = dsm3_pkg::ST_PAIR;
          end
        end else if (covered) begin
          state_next = dsm3_pkg::ST_ACC;
        end
      end
      dsm3_pkg::ST_ACC: begin
        state_next = stk_empty ? dsm3_pkg::ST_PAIR : dsm3_pkg::ST_VISIT;
      end
      dsm3_pkg::ST_PAIR: begin
        if (kc == 2'd3) begin
          state_next = dsm3_pkg::ST_OUT;
        end
      end
      dsm3_pkg::ST_OUT: begin
        if (!result_stall) begin
          state_next = dsm3_pkg::ST_IDLE;
        end
      end
      default: state_next = dsm3_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= dsm3_pkg::ST_CLEAR;
      clr_addr      <= '0;
      string_length <= LW'(MAX_LENGTH);
      sp            <= '0;
      kc            <= '0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        string_length <= cfg_len;
      end
      case (state)
        dsm3_pkg::ST_CLEAR: begin
          clr_addr <= clr_addr + IDXW'(1);
        end
        dsm3_pkg::ST_IDLE: begin
          idx       <= IDXW'(1);
          lo        <= LW'(1);
          hi        <= string_length;
          pos       <= LW'(update_position);
          digit_res <= dsm3_pkg::digit_mod3(new_digit);
          first     <= LW'(query_first);
          last      <= LW'(query_last);
          acc       <= '0;
          sp        <= '0;
          kc        <= '0;
          sum       <= '0;
        end
        dsm3_pkg::ST_DOWN: begin
          if (is_leaf) begin
            cur <= leaf_node;
          end else if (pos <= mid) begin
            idx <= {idx[IDXW-2:0], 1'b0};
            hi  <= mid;
          end else begin
            idx <= {idx[IDXW-2:0], 1'b1};
            lo  <= mid + LW'(1);
          end
        end
        dsm3_pkg::ST_MERGE: begin
          cur <= merged;
          idx <= parent;
        end
        dsm3_pkg::ST_VISIT: begin
          if (disjoint) begin
            // pop the next pending right child
            if (!stk_empty) begin
              idx <= stk_idx[SIW'(sp - SPW'(1))];
              lo  <= stk_lo[SIW'(sp - SPW'(1))];
              hi  <= stk_hi[SIW'(sp - SPW'(1))];
              sp  <= sp - SPW'(1);
            end
          end else if (!covered) begin
            stk_idx[SIW'(sp)] <= {idx[IDXW-2:0], 1'b1};
            stk_lo[SIW'(sp)]  <= mid + LW'(1);
            stk_hi[SIW'(sp)]  <= hi;
            sp  <= sp + SPW'(1);
            idx <= {idx[IDXW-2:0], 1'b0};
            hi  <= mid;
          end
        end
        dsm3_pkg::ST_ACC: begin
          acc <= acc_joined;
          if (!stk_empty) begin
            idx <= stk_idx[SIW'(sp - SPW'(1))];
            lo  <= stk_lo[SIW'(sp - SPW'(1))];
            hi  <= stk_hi[SIW'(sp - SPW'(1))];
            sp  <= sp - SPW'(1);
          end
        end
        dsm3_pkg::ST_PAIR: begin
          // one product per cycle, halve and add the previous one
          prod <= PW'(c_sel * (c_sel - (CW+1)'(1)));
          kc   <= kc + 2'd1;
          if (kc != 2'd0) begin
            sum <= total;
          end
          if (kc == 2'd3) begin
            substring_count <= (64'(total) > 64'hFFFF_FFFF) ? '1 :
                               dsm3_pkg::COUNT_W'(total);
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (accept && opcode == dsm3_pkg::OP_WRITE) |=> !result_valid)
    else $error("write word produced a result");

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SPW'(STK_DEPTH))
    else $error("traversal stack overflow");

  a_result_from_pair: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == dsm3_pkg::ST_PAIR)
    else $error("result shown without pair count");
`endif

endmodule
